// File: hw/rtl/obsp_pkg.sv
// Shared types, constants and fixed-point helpers for the oriented box support point block.
// No dependencies.
`default_nettype none

package obsp_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;

   localparam int FRAC_BITS = 16;

   // corner sign masks, bit k set means +h for corner k
   localparam logic [7:0] SGN_X = 8'b0110_0110;
   localparam logic [7:0] SGN_Y = 8'b1100_1100;
   localparam logic [7:0] SGN_Z = 8'b1111_0000;

   localparam logic [1:0] REG_HX = 2'd0;
   localparam logic [1:0] REG_HY = 2'd1;
   localparam logic [1:0] REG_HZ = 2'd2;

   function automatic wide_type mul32(input word_type a, input word_type b);
      wide_type ea;
      wide_type eb;
      ea = wide_type'(a);
      eb = wide_type'(b);
      return ea * eb;
   endfunction

   // floor of a product scaled down by the fraction bits
   function automatic wide_type flr(input wide_type p);
      return p >>> FRAC_BITS;
   endfunction

   // floor of +p or -p
   function automatic wide_type fsel(input wide_type p, input logic pos);
      wide_type n;
      n = -p;
      return pos ? (p >>> FRAC_BITS) : (n >>> FRAC_BITS);
   endfunction

   function automatic word_type sat32(input wide_type v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/oriented_box_support_point.sv
// Oriented box support point: 3 extents on an APB-style port, 8 corners rotated, scored and
// reduced, then a bias along the normalized direction. Uses obsp_pkg.
// Throughput: one request every cycle; busy is always low and the pipeline never stalls.
// The latency is set by the 32-step square-root pipeline and the 32-step divider pipeline
// that form the direction length and the bias offset, one result bit per stage.
// Reset clears the valid bits and sets all half extents to 1.0.
`default_nettype none

module oriented_box_support_point (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire obsp_pkg::word_type  req_dir_x,
   input  wire obsp_pkg::word_type  req_dir_y,
   input  wire obsp_pkg::word_type  req_dir_z,
   input  wire obsp_pkg::word_type  req_pos_x,
   input  wire obsp_pkg::word_type  req_pos_y,
   input  wire obsp_pkg::word_type  req_pos_z,
   input  wire obsp_pkg::word_type  req_rot_w,
   input  wire obsp_pkg::word_type  req_rot_x,
   input  wire obsp_pkg::word_type  req_rot_y,
   input  wire obsp_pkg::word_type  req_rot_z,
   input  wire obsp_pkg::word_type  req_bias,
   output logic                     rsp_strobe,
   output obsp_pkg::word_type       rsp_point_x,
   output obsp_pkg::word_type       rsp_point_y,
   output obsp_pkg::word_type       rsp_point_z,
   input  wire                      psel,
   input  wire                      penable,
   input  wire                      pwrite,
   input  wire  [3:0]               paddr,
   input  wire  [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import obsp_pkg::*;

   localparam int SQ_STEPS  = 32;
   localparam int DV_STEPS  = 32;
   localparam int SQ_FIRST  = 2;
   localparam int SQ_END    = SQ_FIRST + SQ_STEPS;
   localparam int DV_END    = SQ_END + 1 + DV_STEPS;
   localparam int TREE_END  = 9;
   localparam int DL_LAST   = DV_END - TREE_END;
   localparam int OUT_STAGE = DV_END + 1;

   // ---------------- configuration ----------------
   logic [30:0] hx_ff, hy_ff, hz_ff;
   word_type    h [3];
   logic        cfg_wr;

   assign cfg_wr = psel & penable & pwrite;
   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign h[0]   = $signed({1'b0, hx_ff});
   assign h[1]   = $signed({1'b0, hy_ff});
   assign h[2]   = $signed({1'b0, hz_ff});

   always_comb begin
      case (paddr[3:2])
         REG_HX:  prdata = {1'b0, hx_ff};
         REG_HY:  prdata = {1'b0, hy_ff};
         REG_HZ:  prdata = {1'b0, hz_ff};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hx_ff <= 31'd65536;
         hy_ff <= 31'd65536;
         hz_ff <= 31'd65536;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_HX:  hx_ff <= pwdata[30:0];
            REG_HY:  hy_ff <= pwdata[30:0];
            REG_HZ:  hz_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   // ---------------- valid line ----------------
   logic [OUT_STAGE:0] v_ff, v_in;

   assign v_in = {v_ff[OUT_STAGE-1:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // ---------------- stage registers ----------------
   word_type dir0_ff [3], pos0_ff [3], u0_ff [3], w0_ff, bias0_ff;
   word_type dir0_in [3], pos0_in [3], u0_in [3], w0_in, bias0_in;

   wide_type p1_ff [3][3], uu1_ff [3], dd1_ff [3], bd1_ff [3], ww1_ff;
   wide_type p1_in [3][3], uu1_in [3], dd1_in [3], bd1_in [3], ww1_in;
   word_type dir1_ff [3], pos1_ff [3], u1_ff [3], w1_ff;

   word_type s2_ff, s2_in, d2_ff [8], d2_in [8], c2_ff [8][3], c2_in [8][3];
   word_type dir2_ff [3], pos2_ff [3], u2_ff [3], w2_ff;

   wide_type sh3_ff [3], sh3_in [3], du3_ff [8][3], du3_in [8][3];
   wide_type wc3_ff [8][3], wc3_in [8][3];
   word_type dir3_ff [3], pos3_ff [3];

   word_type p4_ff [8][3], p4_in [8][3], dir4_ff [3];
   wide_type dp5_ff [8][3], dp5_in [8][3];
   word_type p5_ff [8][3];
   wide_type sc6_ff [8], sc6_in [8];
   word_type p6_ff [8][3];

   wide_type sc7_ff [4], sc7_in [4], sc8_ff [2], sc8_in [2];
   word_type pt7_ff [4][3], pt7_in [4][3], pt8_ff [2][3], pt8_in [2][3];

   word_type dl_ff [DL_LAST+1][3], dl_in [DL_LAST+1][3];

   // square root chain, index 0 is the stage after the products
   logic [63:0] sqn_ff [SQ_STEPS+1], sqn_in [SQ_STEPS+1];
   logic [63:0] sqr_ff [SQ_STEPS+1], sqr_in [SQ_STEPS+1];
   logic [62:0] om_ff [SQ_STEPS+1][3], om_in [SQ_STEPS+1][3];
   logic        on_ff [SQ_STEPS+1][3], on_in [SQ_STEPS+1][3];

   // divider chain
   logic [62:0] dr_ff [DV_STEPS+1][3], dr_in [DV_STEPS+1][3];
   logic [31:0] dq_ff [DV_STEPS+1][3], dq_in [DV_STEPS+1][3];
   logic        dn_ff [DV_STEPS+1][3], dn_in [DV_STEPS+1][3];
   logic [31:0] dd_ff [DV_STEPS+1], dd_in [DV_STEPS+1];

   word_type pt_out_ff [3], pt_out_in [3];

   // ---------------- stage 0: request beat ----------------
   always_comb begin
      dir0_in[0] = req_dir_x;
      dir0_in[1] = req_dir_y;
      dir0_in[2] = req_dir_z;
      pos0_in[0] = req_pos_x;
      pos0_in[1] = req_pos_y;
      pos0_in[2] = req_pos_z;
      u0_in[0]   = req_rot_x;
      u0_in[1]   = req_rot_y;
      u0_in[2]   = req_rot_z;
      w0_in      = req_rot_w;
      bias0_in   = req_bias;
   end

   // ---------------- stage 1: first products ----------------
   always_comb begin
      ww1_in = mul32(w0_ff, w0_ff);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p1_in[i][j] = mul32(u0_ff[i], h[j]);
         end
         uu1_in[i] = mul32(u0_ff[i], u0_ff[i]);
         dd1_in[i] = mul32(dir0_ff[i], dir0_ff[i]);
         bd1_in[i] = mul32(bias0_ff, dir0_ff[i]);
      end
   end

   // ---------------- stage 2: s, dot and cross per corner ----------------
   always_comb begin
      logic sx, sy, sz;
      s2_in = sat32(flr(ww1_ff) - flr(uu1_ff[0]) - flr(uu1_ff[1]) - flr(uu1_ff[2]));
      for (int k = 0; k < 8; k++) begin
         sx = SGN_X[k];
         sy = SGN_Y[k];
         sz = SGN_Z[k];
         d2_in[k] = sat32(fsel(p1_ff[0][0], sx) + fsel(p1_ff[1][1], sy)
                        + fsel(p1_ff[2][2], sz));
         c2_in[k][0] = sat32(fsel(p1_ff[1][2], sz) - fsel(p1_ff[2][1], sy));
         c2_in[k][1] = sat32(fsel(p1_ff[2][0], sx) - fsel(p1_ff[0][2], sz));
         c2_in[k][2] = sat32(fsel(p1_ff[0][1], sy) - fsel(p1_ff[1][0], sx));
      end
   end

   // ---------------- stage 3: rotation products ----------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh3_in[i] = mul32(s2_ff, h[i]);
      end
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 3; i++) begin
            du3_in[k][i] = mul32(d2_ff[k], u2_ff[i]);
            wc3_in[k][i] = mul32(w2_ff, c2_ff[k][i]);
         end
      end
   end

   // ---------------- stage 4: rotated, translated corners ----------------
   always_comb begin
      logic     sg [3];
      wide_type r;
      for (int k = 0; k < 8; k++) begin
         sg[0] = SGN_X[k];
         sg[1] = SGN_Y[k];
         sg[2] = SGN_Z[k];
         for (int i = 0; i < 3; i++) begin
            r = fsel(sh3_ff[i], sg[i]) + (flr(du3_ff[k][i]) <<< 1)
              + (flr(wc3_ff[k][i]) <<< 1);
            p4_in[k][i] = sat32(r + wide_type'(pos3_ff[i]));
         end
      end
   end

   // ---------------- stages 5 and 6: scores ----------------
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 3; i++) begin
            dp5_in[k][i] = mul32(dir4_ff[i], p4_ff[k][i]);
         end
         sc6_in[k] = flr(dp5_ff[k][0]) + flr(dp5_ff[k][1]) + flr(dp5_ff[k][2]);
      end
   end

   // ---------------- stages 7 to 9: max tree, a tie keeps the lower corner ----------------
   always_comb begin
      logic take_b;
      for (int m = 0; m < 4; m++) begin
         take_b    = sc6_ff[2*m+1] > sc6_ff[2*m];
         sc7_in[m] = take_b ? sc6_ff[2*m+1] : sc6_ff[2*m];
         for (int i = 0; i < 3; i++) begin
            pt7_in[m][i] = take_b ? p6_ff[2*m+1][i] : p6_ff[2*m][i];
         end
      end
      for (int m = 0; m < 2; m++) begin
         take_b    = sc7_ff[2*m+1] > sc7_ff[2*m];
         sc8_in[m] = take_b ? sc7_ff[2*m+1] : sc7_ff[2*m];
         for (int i = 0; i < 3; i++) begin
            pt8_in[m][i] = take_b ? pt7_ff[2*m+1][i] : pt7_ff[2*m][i];
         end
      end
      take_b = sc8_ff[1] > sc8_ff[0];
      for (int i = 0; i < 3; i++) begin
         dl_in[0][i] = take_b ? pt8_ff[1][i] : pt8_ff[0][i];
      end
      for (int t = 1; t <= DL_LAST; t++) begin
         dl_in[t] = dl_ff[t-1];
      end
   end

   // ---------------- square root, one result bit per stage ----------------
   always_comb begin
      logic [63:0] bit_v;
      logic [64:0] trial;
      wide_type    neg_v;
      sqn_in[0] = 64'(dd1_ff[0]) + 64'(dd1_ff[1]) + 64'(dd1_ff[2]);
      sqr_in[0] = 64'd0;
      for (int i = 0; i < 3; i++) begin
         neg_v = -bd1_ff[i];
         on_in[0][i] = bd1_ff[i][63];
         om_in[0][i] = bd1_ff[i][63] ? neg_v[62:0] : bd1_ff[i][62:0];
      end
      for (int k = 0; k < SQ_STEPS; k++) begin
         bit_v = 64'd1 << (62 - 2 * k);
         trial = {1'b0, sqr_ff[k]} + {1'b0, bit_v};
         if ({1'b0, sqn_ff[k]} >= trial) begin
            sqn_in[k+1] = sqn_ff[k] - trial[63:0];
            sqr_in[k+1] = (sqr_ff[k] >> 1) + bit_v;
         end else begin
            sqn_in[k+1] = sqn_ff[k];
            sqr_in[k+1] = sqr_ff[k] >> 1;
         end
         om_in[k+1] = om_ff[k];
         on_in[k+1] = on_ff[k];
      end
   end

   // ---------------- divider, one quotient bit per stage ----------------
   always_comb begin
      logic [63:0] sub_v;
      logic [64:0] diff;
      dd_in[0] = sqr_ff[SQ_STEPS][31:0];
      for (int i = 0; i < 3; i++) begin
         dr_in[0][i] = om_ff[SQ_STEPS][i];
         dq_in[0][i] = 32'd0;
         dn_in[0][i] = on_ff[SQ_STEPS][i];
      end
      for (int j = 0; j < DV_STEPS; j++) begin
         dd_in[j+1] = dd_ff[j];
         for (int i = 0; i < 3; i++) begin
            sub_v = {32'd0, dd_ff[j]} << (DV_STEPS - 1 - j);
            diff  = {2'b00, dr_ff[j][i]} - {1'b0, sub_v};
            dn_in[j+1][i] = dn_ff[j][i];
            dq_in[j+1][i] = dq_ff[j][i];
            if (!diff[64]) begin
               dr_in[j+1][i] = diff[62:0];
               dq_in[j+1][i][DV_STEPS-1-j] = 1'b1;
            end else begin
               dr_in[j+1][i] = dr_ff[j][i];
            end
         end
      end
   end

   // ---------------- output: point plus offset ----------------
   always_comb begin
      wide_type off;
      wide_type qv;
      for (int i = 0; i < 3; i++) begin
         qv  = wide_type'({32'd0, dq_ff[DV_STEPS][i]});
         off = dn_ff[DV_STEPS][i] ? -qv : qv;
         if (dd_ff[DV_STEPS] == 32'd0) begin
            off = '0;
         end
         pt_out_in[i] = sat32(wide_type'(dl_ff[DL_LAST][i]) + off);
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      dir0_ff  <= dir0_in;
      pos0_ff  <= pos0_in;
      u0_ff    <= u0_in;
      w0_ff    <= w0_in;
      bias0_ff <= bias0_in;

      p1_ff    <= p1_in;
      uu1_ff   <= uu1_in;
      dd1_ff   <= dd1_in;
      bd1_ff   <= bd1_in;
      ww1_ff   <= ww1_in;
      dir1_ff  <= dir0_ff;
      pos1_ff  <= pos0_ff;
      u1_ff    <= u0_ff;
      w1_ff    <= w0_ff;

      s2_ff    <= s2_in;
      d2_ff    <= d2_in;
      c2_ff    <= c2_in;
      dir2_ff  <= dir1_ff;
      pos2_ff  <= pos1_ff;
      u2_ff    <= u1_ff;
      w2_ff    <= w1_ff;

      sh3_ff   <= sh3_in;
      du3_ff   <= du3_in;
      wc3_ff   <= wc3_in;
      dir3_ff  <= dir2_ff;
      pos3_ff  <= pos2_ff;

      p4_ff    <= p4_in;
      dir4_ff  <= dir3_ff;

      dp5_ff   <= dp5_in;
      p5_ff    <= p4_ff;
      sc6_ff   <= sc6_in;
      p6_ff    <= p5_ff;

      sc7_ff   <= sc7_in;
      pt7_ff   <= pt7_in;
      sc8_ff   <= sc8_in;
      pt8_ff   <= pt8_in;
      dl_ff    <= dl_in;

      sqn_ff   <= sqn_in;
      sqr_ff   <= sqr_in;
      om_ff    <= om_in;
      on_ff    <= on_in;

      dr_ff    <= dr_in;
      dq_ff    <= dq_in;
      dn_ff    <= dn_in;
      dd_ff    <= dd_in;

      pt_out_ff <= pt_out_in;
   end

   assign rsp_strobe  = v_ff[OUT_STAGE];
   assign rsp_point_x = pt_out_ff[0];
   assign rsp_point_y = pt_out_ff[1];
   assign rsp_point_z = pt_out_ff[2];

endmodule

`default_nettype wire
